// ===== src/fat12_cluster_chain_walker_core_defines.svh =====
// ----------------------------------------------------------------------------
// fat12_cluster_chain_walker_core_defines.svh
// Assertion macros shared by the FAT12 chain walker RTL.
// ----------------------------------------------------------------------------
`ifndef FAT12_CLUSTER_CHAIN_WALKER_CORE_DEFINES_SVH
`define FAT12_CLUSTER_CHAIN_WALKER_CORE_DEFINES_SVH

// Same-cycle implication, checked while out of reset
`define FCW_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked while out of reset
`define FCW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/fcw_pkg.sv =====
// ----------------------------------------------------------------------------
// fcw_pkg
// Types and constants of the FAT12 cluster chain walker.
// ----------------------------------------------------------------------------
package fcw_pkg;

    // Table geometry
    localparam int FAT_BYTES = 8192;
    localparam int FAT_AW    = $clog2(FAT_BYTES);
    localparam int MAX_CHAIN = 64;

    // Field widths
    localparam int CL_W     = 12;
    localparam int BADDR_W  = 13;
    localparam int BYTE_W   = 8;
    localparam int SECTOR_W = 20;
    localparam int POS_W    = 6;
    localparam int DS_W     = 16;
    localparam int CS_W     = 8;
    localparam int CFG_IDX_W = 2;

    // Stream widths
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 40;

    // Entry codes and masks
    localparam logic [CL_W-1:0]     END_MARK    = 12'hFF8;
    localparam logic [CL_W-1:0]     BAD_MARK    = 12'hFF7;
    localparam logic [CL_W-1:0]     FIRST_DATA  = 12'h002;
    localparam logic [BYTE_W-1:0]   LOW_NIBBLE  = 8'h0F;
    localparam logic [BYTE_W-1:0]   HIGH_NIBBLE = 8'hF0;
    localparam logic [SECTOR_W-1:0] SECTOR_MAX  = 20'hFFFFF;
    localparam logic [POS_W-1:0]    POS_LAST    = POS_W'(MAX_CHAIN - 1);

    // Input item kinds
    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_WALK = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DATA_START      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLUSTER_SECTORS = 2'd1;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_BAD   = 2'd1,
        ST_TRUNC = 2'd2
    } t_status;

    // Walk sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_HI,
        S_EVAL,
        S_ERR
    } t_state;

endpackage

// ===== src/fcw_ram.sv =====
// ----------------------------------------------------------------------------
// fcw_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module fcw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8192,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, data held while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/fat12_cluster_chain_walker_core.sv =====
// ----------------------------------------------------------------------------
// fat12_cluster_chain_walker_core
// Holds a FAT12 table in RAM and walks cluster chains, one result per cluster.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream takes two kinds of transaction, chosen by tuser. A load
//   writes one table byte into the table RAM in the cycle it is accepted.
//   A walk names a start cluster; unless that is an end mark, the block then
//   follows the chain and sends one master-stream transaction per cluster,
//   tlast on the final one, with the cluster's first sector, its position
//   and a status in tuser. Loads are accepted back to back while idle. Each
//   cluster takes two byte reads through the single read port of the table
//   RAM, the low byte as the walk starts or the previous cluster is emitted
//   and the high byte in S_HI. The slave side stays not ready until the last
//   result of a walk sits in the output register.
//   A stalled master side holds the output register and freezes the walk.
//   Reset clears the sequencer, the output valid and sets the registers to
//   data start 0 and one sector per cluster; table contents are kept and are
//   undefined until loaded. The configuration channel is always ready and is to
//   be written only while no walk is running; the block does not enforce it.
// ----------------------------------------------------------------------------
`include "fat12_cluster_chain_walker_core_defines.svh"

module fat12_cluster_chain_walker_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // slave stream
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // [12:0] byte_addr, [20:13] byte_value, [32:21] start_cluster, rest zero
    input  logic [fcw_pkg::S_TDATA_W-1:0]      i_s_axis_tdata,
    // [0] kind
    input  logic                               i_s_axis_tuser,
    // master stream
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // [19:0] sector, [31:20] cluster, [37:32] position, rest zero
    output logic [fcw_pkg::M_TDATA_W-1:0]      o_m_axis_tdata,
    // [1:0] status
    output logic [1:0]                         o_m_axis_tuser,
    output logic                               o_m_axis_tlast,
    // configuration write channel
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [fcw_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [fcw_pkg::DS_W-1:0]           i_cfg_data
);

    localparam int CL_W  = fcw_pkg::CL_W;
    localparam int BW    = fcw_pkg::BYTE_W;
    localparam int AW    = fcw_pkg::BADDR_W;
    localparam int SW    = fcw_pkg::SECTOR_W;
    localparam int PW    = fcw_pkg::POS_W;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    fcw_pkg::t_state   r_state, n_state;
    logic [CL_W-1:0]   r_cur, n_cur;
    logic [PW-1:0]     r_pos, n_pos;
    logic [BW-1:0]     r_lo, n_lo;
    logic              r_lo_ok, n_lo_ok;
    logic              r_hi_ok, n_hi_ok;
    logic [AW-1:0]     r_hi_addr, n_hi_addr;
    logic [SW-1:0]     r_sector, n_sector;
    logic [fcw_pkg::DS_W-1:0] r_ds;
    logic [fcw_pkg::CS_W-1:0] r_cs;

    logic              r_o_valid, n_o_valid;
    logic [SW-1:0]     r_o_sector, n_o_sector;
    logic [CL_W-1:0]   r_o_cluster, n_o_cluster;
    logic [PW-1:0]     r_o_pos, n_o_pos;
    logic              r_o_last, n_o_last;
    fcw_pkg::t_status  r_o_status, n_o_status;

    // ------------------------------------------------------------------
    // Stream fields and handshakes
    // ------------------------------------------------------------------
    logic [AW-1:0]   in_byte_addr;
    logic [BW-1:0]   in_byte_value;
    logic [CL_W-1:0] in_start;
    logic            s_accept;
    logic            out_free;

    assign in_byte_addr  = i_s_axis_tdata[12:0];
    assign in_byte_value = i_s_axis_tdata[20:13];
    assign in_start      = i_s_axis_tdata[32:21];

    assign o_s_axis_tready = (r_state == fcw_pkg::S_IDLE);
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free        = !r_o_valid || i_m_axis_tready;
    assign o_cfg_ready     = 1'b1;

    // ------------------------------------------------------------------
    // Table RAM
    // ------------------------------------------------------------------
    logic                       ram_we;
    logic [fcw_pkg::FAT_AW-1:0] ram_waddr;
    logic                       ram_re;
    logic [AW-1:0]              ram_raddr;
    logic [BW-1:0]              ram_rdata;

    assign ram_we    = s_accept && (i_s_axis_tuser == fcw_pkg::KIND_LOAD) &&
                       (32'(in_byte_addr) < fcw_pkg::FAT_BYTES);
    assign ram_waddr = in_byte_addr[fcw_pkg::FAT_AW-1:0];

    fcw_ram #(
        .WIDTH (BW),
        .DEPTH (fcw_pkg::FAT_BYTES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (in_byte_value),
        .i_re    (ram_re),
        .i_raddr (ram_raddr[fcw_pkg::FAT_AW-1:0]),
        .o_rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Entry unpack: low byte was captured, high byte arrives from RAM
    // ------------------------------------------------------------------
    logic [BW-1:0]   lo_b, hi_b;
    logic [CL_W-1:0] entry;
    logic            entry_end;

    assign lo_b  = r_lo_ok ? r_lo : '0;
    assign hi_b  = r_hi_ok ? ram_rdata : '0;
    assign entry = r_cur[0] ? {hi_b, 4'((lo_b & fcw_pkg::HIGH_NIBBLE) >> 4)}
                            : {4'(hi_b & fcw_pkg::LOW_NIBBLE), lo_b};
    assign entry_end = (entry >= fcw_pkg::END_MARK);

    // ------------------------------------------------------------------
    // Launch of one chain step: start cluster or the entry just read
    // ------------------------------------------------------------------
    logic [CL_W-1:0] l_cl;
    logic            l_end;
    logic            l_bad;
    logic [AW-1:0]   l_base;
    logic [AW-1:0]   l_lo_addr;

    assign l_cl      = (r_state == fcw_pkg::S_IDLE) ? in_start : entry;
    assign l_end     = (l_cl >= fcw_pkg::END_MARK);
    assign l_bad     = (l_cl < fcw_pkg::FIRST_DATA) || (l_cl == fcw_pkg::BAD_MARK);
    assign l_base    = {2'b00, l_cl[CL_W-1:1]} + {1'b0, l_cl[CL_W-1:1], 1'b0};
    assign l_lo_addr = l_base + AW'(l_cl[0]);

    // ------------------------------------------------------------------
    // First sector of the current cluster, saturated
    // ------------------------------------------------------------------
    logic [CL_W-1:0] sec_rel;
    logic [SW-1:0]   sec_prod;
    logic [SW:0]     sec_sum;
    logic [SW-1:0]   sec_value;

    assign sec_rel   = r_cur - fcw_pkg::FIRST_DATA;
    assign sec_prod  = SW'(sec_rel * r_cs);
    assign sec_sum   = {1'b0, sec_prod} + (SW+1)'(r_ds);
    assign sec_value = sec_sum[SW] ? fcw_pkg::SECTOR_MAX : sec_sum[SW-1:0];

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            fcw_pkg::S_IDLE: begin
                if (s_accept && (i_s_axis_tuser == fcw_pkg::KIND_WALK) && !l_end) begin
                    n_state = l_bad ? fcw_pkg::S_ERR : fcw_pkg::S_HI;
                end
            end
            fcw_pkg::S_HI: begin
                n_state = fcw_pkg::S_EVAL;
            end
            fcw_pkg::S_EVAL: begin
                if (out_free) begin
                    if (entry_end || (r_pos == fcw_pkg::POS_LAST)) begin
                        n_state = fcw_pkg::S_IDLE;
                    end else begin
                        n_state = l_bad ? fcw_pkg::S_ERR : fcw_pkg::S_HI;
                    end
                end
            end
            fcw_pkg::S_ERR: begin
                if (out_free) begin
                    n_state = fcw_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = fcw_pkg::S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath and output register controls
    // ------------------------------------------------------------------
    always_comb begin
        n_cur       = r_cur;
        n_pos       = r_pos;
        n_lo        = r_lo;
        n_lo_ok     = r_lo_ok;
        n_hi_ok     = r_hi_ok;
        n_hi_addr   = r_hi_addr;
        n_sector    = r_sector;
        ram_re      = 1'b0;
        ram_raddr   = l_lo_addr;
        n_o_valid   = r_o_valid && !i_m_axis_tready;
        n_o_sector  = r_o_sector;
        n_o_cluster = r_o_cluster;
        n_o_pos     = r_o_pos;
        n_o_last    = r_o_last;
        n_o_status  = r_o_status;
        case (r_state)
            fcw_pkg::S_IDLE: begin
                // start a walk: issue the low byte read
                if (s_accept && (i_s_axis_tuser == fcw_pkg::KIND_WALK)) begin
                    n_cur     = l_cl;
                    n_pos     = '0;
                    n_lo_ok   = (32'(l_lo_addr) < fcw_pkg::FAT_BYTES);
                    n_hi_addr = l_lo_addr + AW'(1);
                    ram_re    = !l_end && !l_bad;
                end
            end
            fcw_pkg::S_HI: begin
                // capture low byte, issue high byte read, form the sector
                n_lo      = ram_rdata;
                n_hi_ok   = (32'(r_hi_addr) < fcw_pkg::FAT_BYTES);
                ram_raddr = r_hi_addr;
                ram_re    = 1'b1;
                n_sector  = sec_value;
            end
            fcw_pkg::S_EVAL: begin
                // emit the current cluster and advance to its successor
                if (out_free) begin
                    n_o_valid   = 1'b1;
                    n_o_sector  = r_sector;
                    n_o_cluster = r_cur;
                    n_o_pos     = r_pos;
                    n_o_last    = entry_end || (r_pos == fcw_pkg::POS_LAST);
                    n_o_status  = (!entry_end && (r_pos == fcw_pkg::POS_LAST)) ?
                                  fcw_pkg::ST_TRUNC : fcw_pkg::ST_OK;
                    if (!entry_end && (r_pos != fcw_pkg::POS_LAST)) begin
                        n_cur     = entry;
                        n_pos     = r_pos + PW'(1);
                        n_lo_ok   = (32'(l_lo_addr) < fcw_pkg::FAT_BYTES);
                        n_hi_addr = l_lo_addr + AW'(1);
                        ram_re    = !l_bad;
                    end
                end
            end
            fcw_pkg::S_ERR: begin
                // emit the invalid cluster and stop
                if (out_free) begin
                    n_o_valid   = 1'b1;
                    n_o_sector  = '0;
                    n_o_cluster = r_cur;
                    n_o_pos     = r_pos;
                    n_o_last    = 1'b1;
                    n_o_status  = fcw_pkg::ST_BAD;
                end
            end
            default: begin
                n_o_valid = r_o_valid && !i_m_axis_tready;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= fcw_pkg::S_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_o_valid <= n_o_valid;
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ds <= '0;
            r_cs <= fcw_pkg::CS_W'(1);
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == fcw_pkg::CFG_DATA_START) begin
                r_ds <= i_cfg_data;
            end else if (i_cfg_index == fcw_pkg::CFG_CLUSTER_SECTORS) begin
                r_cs <= i_cfg_data[fcw_pkg::CS_W-1:0];
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_cur       <= n_cur;
        r_pos       <= n_pos;
        r_lo        <= n_lo;
        r_lo_ok     <= n_lo_ok;
        r_hi_ok     <= n_hi_ok;
        r_hi_addr   <= n_hi_addr;
        r_sector    <= n_sector;
        r_o_sector  <= n_o_sector;
        r_o_cluster <= n_o_cluster;
        r_o_pos     <= n_o_pos;
        r_o_last    <= n_o_last;
        r_o_status  <= n_o_status;
    end

    // ------------------------------------------------------------------
    // Master stream
    // ------------------------------------------------------------------
    assign o_m_axis_tvalid = r_o_valid;
    assign o_m_axis_tdata  = {2'b00, r_o_pos, r_o_cluster, r_o_sector};
    assign o_m_axis_tuser  = r_o_status;
    assign o_m_axis_tlast  = r_o_last;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `FCW_ASSERT_NEXT(a_hi_then_eval, i_clk, i_rst_n, r_state == fcw_pkg::S_HI, r_state == fcw_pkg::S_EVAL, "high byte read not followed by evaluation")
    `FCW_ASSERT_NEXT(a_last_goes_idle, i_clk, i_rst_n, (r_state != fcw_pkg::S_IDLE) && out_free && n_o_last && n_o_valid, r_state == fcw_pkg::S_IDLE, "walk continues after its last result")
    `FCW_ASSERT_NOW(a_cap_is_last, i_clk, i_rst_n, r_o_valid && (r_o_pos == fcw_pkg::POS_LAST), r_o_last, "result at chain cap is not marked last")
    `FCW_ASSERT_NOW(a_bad_zero_sector, i_clk, i_rst_n, r_o_valid && (r_o_status == fcw_pkg::ST_BAD), r_o_last && (r_o_sector == '0), "invalid cluster result not last or sector not zero")

endmodule
